// ===== rtl/core/srs_pkg.sv =====
// Shared constants for the smooth region segmenter.
package srs_pkg;

    // Configuration register indexes
    localparam logic REG_DIFF_THRESHOLD = 1'b0;
    localparam logic REG_MIN_RUN        = 1'b1;

    // Register reset values
    localparam logic [15:0] DIFF_THRESHOLD_RESET = 16'd256;
    localparam logic [11:0] MIN_RUN_RESET        = 12'd5;

    // Default stream index range
    localparam int MAX_POINTS_DEFAULT = 4096;

    // Log2 fraction: one result bit per squaring step
    localparam int SQ_STEPS = 16;

    // 2*ln(2) in Q.16
    localparam logic signed [17:0] TWO_LN2_Q16 = 18'sd90852;

    // Half of the final 2^24 scale, for round-half-up
    localparam logic signed [39:0] ROUND_HALF = 40'sd8388608;

    // Goodness for zero variance
    localparam logic signed [15:0] G_SAT = 16'sh7FFF;

    // Pair counter ceiling
    localparam logic [11:0] PAIR_MAX = 12'hFFF;

endpackage

// ===== rtl/core/smooth_region_segmenter.sv =====
// Smooth region segmenter: goodness pipeline and run scanner.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_ready, variance, x_coord,    | in
//          | last_point                                |
//  result  | out_valid, out_ready, start_index,        | out
//          | stop_index, run_length, x_start, x_stop,  |
//          | region_number                             |
//  config  | cfg_write, cfg_index, cfg_data            | in
//
// One word is taken per cycle while the pipeline advances. A word reaches
// the result register through the input register, normalize stage, 16
// squaring stages of the log2 unit (one 32x32 multiplier each), scale
// multiply and rounding, then the run scanner writes the result register.
// Reset clears all valid bits and run state, and sets config registers to their defaults.
// The whole pipeline holds only while a result sits unread in the result
// register; otherwise it advances every cycle.
module smooth_region_segmenter #(
    parameter int MAX_POINTS = srs_pkg::MAX_POINTS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        variance,
    input  logic signed [31:0] x_coord,
    input  logic               last_point,

    output logic               out_valid,
    input  logic               out_ready,
    output logic [11:0]        start_index,
    output logic [11:0]        stop_index,
    output logic [11:0]        run_length,
    output logic signed [31:0] x_start,
    output logic signed [31:0] x_stop,
    output logic [10:0]        region_number,

    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int SQ_N  = srs_pkg::SQ_STEPS;

    typedef logic [IDX_W-1:0] idx_t;

    // Running scan state touched by a scan position
    typedef struct packed {
        logic [11:0] pair_count;
        idx_t        run_begin;
        logic [31:0] run_begin_x;
        logic [11:0] region_total;
    } run_t;

    typedef struct packed {
        logic        emit;
        logic [11:0] start_idx;
        logic [11:0] stop_idx;
        logic [11:0] length;
        logic [31:0] x_begin;
        logic [31:0] x_end;
        logic [10:0] number;
    } region_t;

    typedef struct packed {
        run_t    run;
        region_t region;
    } scan_t;

    // Evaluate one scan position: extend a run, close it, or drop it
    function automatic scan_t scan_at(
        input run_t        rs,
        input idx_t        i,
        input logic [31:0] xi,
        input logic        has_prev,
        input logic        c_prev,
        input logic        c_here,
        input logic        c_next,
        input logic [11:0] min_run_v,
        input logic [31:0] x_first_v
    );
        scan_t r;
        r.run    = rs;
        r.region = '0;
        if (c_here) begin
            if (c_next) begin
                if (rs.pair_count != srs_pkg::PAIR_MAX) begin
                    r.run.pair_count = rs.pair_count + 12'd1;
                end
                if (has_prev && !c_prev) begin
                    r.run.run_begin   = i;
                    r.run.run_begin_x = xi;
                end
            end else if (rs.pair_count > min_run_v) begin
                r.region.emit      = 1'b1;
                r.region.start_idx = 12'(32'(rs.run_begin));
                r.region.stop_idx  = 12'(32'(i));
                r.region.length    = 12'(32'(i) - 32'(rs.run_begin));
                r.region.x_begin   = rs.run_begin_x;
                r.region.x_end     = xi;
                r.region.number    = rs.region_total[10:0];
                r.run.pair_count   = '0;
                r.run.region_total = rs.region_total + 12'd1;
            end else begin
                r.run.pair_count  = '0;
                r.run.run_begin   = '0;
                r.run.run_begin_x = x_first_v;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] diff_threshold_reg;
    logic [11:0] min_run_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_threshold_reg <= srs_pkg::DIFF_THRESHOLD_RESET;
            min_run_reg        <= srs_pkg::MIN_RUN_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                srs_pkg::REG_DIFF_THRESHOLD: diff_threshold_reg <= cfg_data;
                srs_pkg::REG_MIN_RUN:        min_run_reg        <= cfg_data[11:0];
                default:                     ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: advance the whole pipeline unless a result is stuck
    // ------------------------------------------------------------------
    logic advance;
    logic out_valid_reg;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic        in_valid_reg;
    logic [31:0] in_var_reg;
    logic [31:0] in_x_reg;
    logic        in_last_reg;

    // ------------------------------------------------------------------
    // Normalize: exponent and mantissa in Q1.31
    // ------------------------------------------------------------------
    logic [4:0]  norm_e;
    logic [31:0] norm_x;
    logic        norm_zero;

    always_comb
    begin
        norm_e = '0;
        for (int b = 1; b < 32; b++)
        begin
            if (in_var_reg[b])
            begin
                norm_e = 5'(b);
            end
        end
        norm_x    = in_var_reg << (5'd31 - norm_e);
        norm_zero = (in_var_reg == 32'd0);
    end

    // ------------------------------------------------------------------
    // Squaring stages: each yields one fraction bit of log2
    // ------------------------------------------------------------------
    logic        sq_valid_reg [0:SQ_N];
    logic [31:0] sq_x_reg     [0:SQ_N];
    logic [15:0] sq_frac_reg  [0:SQ_N];
    logic [4:0]  sq_e_reg     [0:SQ_N];
    logic        sq_zero_reg  [0:SQ_N];
    logic [31:0] sq_xc_reg    [0:SQ_N];
    logic        sq_last_reg  [0:SQ_N];

    logic [31:0] sq_x_next    [1:SQ_N];
    logic [15:0] sq_frac_next [1:SQ_N];

    always_comb
    begin
        logic [63:0] sq_prod;
        logic [32:0] sq_shr;
        sq_prod = '0;
        sq_shr  = '0;
        for (int k = 1; k <= SQ_N; k++)
        begin
            sq_prod         = sq_x_reg[k-1] * sq_x_reg[k-1];
            sq_shr          = sq_prod[63:31];
            sq_x_next[k]    = sq_shr[32] ? sq_shr[32:1] : sq_shr[31:0];
            sq_frac_next[k] = {sq_frac_reg[k-1][14:0], sq_shr[32]};
        end
    end

    // ------------------------------------------------------------------
    // Scale by -2*ln2 and round to Q8.8
    // ------------------------------------------------------------------
    logic signed [20:0] lq;
    logic signed [38:0] mul_next;

    logic               mul_valid_reg;
    logic signed [38:0] mul_reg;
    logic               mul_zero_reg;
    logic [31:0]        mul_xc_reg;
    logic               mul_last_reg;

    // (e - 16) is e with its top bit flipped, read as signed
    assign lq       = $signed({~sq_e_reg[SQ_N][4], sq_e_reg[SQ_N][3:0], sq_frac_reg[SQ_N]});
    assign mul_next = lq * srs_pkg::TWO_LN2_Q16;

    logic signed [39:0] g_sum;
    logic signed [15:0] g_next;

    assign g_sum  = (40'sd0 - 40'(mul_reg)) + srs_pkg::ROUND_HALF;
    assign g_next = mul_zero_reg ? srs_pkg::G_SAT : g_sum[39:24];

    logic               gd_valid_reg;
    logic signed [15:0] gd_g_reg;
    logic [31:0]        gd_xc_reg;
    logic               gd_last_reg;

    // ------------------------------------------------------------------
    // Run scanner state
    // ------------------------------------------------------------------
    idx_t               point_index_reg;
    logic signed [15:0] prev_goodness_reg;
    logic [15:0]        prev_diff_reg;
    logic               flag_older_reg;
    logic               flag_newer_reg;
    logic [31:0]        x_delay_reg [0:1];
    run_t               run_reg;
    logic [31:0]        x_first_reg;
    logic [1:0]         seen_reg;

    logic signed [16:0] dd;
    logic [16:0]        dd_abs;
    logic [15:0]        d_cur;
    logic signed [16:0] dx;
    logic [16:0]        dx_abs;
    logic               cn;

    idx_t        idx_back2;
    idx_t        idx_back1;
    idx_t        point_index_next;
    logic [31:0] x_first_cur;
    run_t        run_base;
    scan_t       scan_a;
    scan_t       scan_b;
    region_t     region_sel;
    run_t        run_next;

    always_comb
    begin
        // Differences of goodness and flag for the point before this one
        dd     = 17'(gd_g_reg) - 17'(prev_goodness_reg);
        dd_abs = dd[16] ? 17'(-dd) : 17'(dd);
        dx     = $signed({1'b0, dd_abs[15:0]}) - $signed({1'b0, prev_diff_reg});
        dx_abs = dx[16] ? 17'(-dx) : 17'(dx);
        if (seen_reg != 2'd0)
        begin
            d_cur = dd_abs[15:0];
            cn    = (dx_abs < {1'b0, diff_threshold_reg});
        end
        else
        begin
            d_cur = '0;
            cn    = 1'b0;
        end

        idx_back2 = (point_index_reg >= IDX_W'(2)) ? point_index_reg - IDX_W'(2)
                                                   : point_index_reg + IDX_W'(MAX_POINTS - 2);
        idx_back1 = (point_index_reg != '0) ? point_index_reg - IDX_W'(1)
                                            : IDX_W'(MAX_POINTS - 1);
        point_index_next = (point_index_reg == IDX_W'(MAX_POINTS - 1)) ? '0
                                                                       : point_index_reg + IDX_W'(1);

        // First point of a stream pins the default run start
        run_base    = run_reg;
        x_first_cur = x_first_reg;
        if (seen_reg == 2'd0)
        begin
            x_first_cur          = gd_xc_reg;
            run_base.run_begin   = '0;
            run_base.run_begin_x = gd_xc_reg;
        end

        // Scan the point two back, now that its successor's flag is known
        scan_a = scan_at(run_base, idx_back2, x_delay_reg[1], seen_reg == 2'd3,
                         flag_older_reg, flag_newer_reg, cn, min_run_reg, x_first_cur);
        if (seen_reg < 2'd2)
        begin
            scan_a.run    = run_base;
            scan_a.region = '0;
        end

        // On the end marker, also close the point just before this one
        scan_b = scan_at(scan_a.run, idx_back1, x_delay_reg[0], seen_reg >= 2'd2,
                         flag_newer_reg, cn, 1'b0, min_run_reg, x_first_cur);
        if (!(gd_last_reg && seen_reg != 2'd0 && !scan_a.region.emit))
        begin
            scan_b.run    = scan_a.run;
            scan_b.region = '0;
        end

        region_sel = scan_a.region.emit ? scan_a.region : scan_b.region;
        run_next   = scan_b.run;
    end

    // ------------------------------------------------------------------
    // Control registers: valid bits, scan state, config-independent
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            for (int k = 0; k <= SQ_N; k++)
            begin
                sq_valid_reg[k] <= 1'b0;
            end
            mul_valid_reg <= 1'b0;
            gd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;

            point_index_reg   <= '0;
            prev_goodness_reg <= '0;
            prev_diff_reg     <= '0;
            flag_older_reg    <= 1'b0;
            flag_newer_reg    <= 1'b0;
            x_delay_reg[0]    <= '0;
            x_delay_reg[1]    <= '0;
            run_reg           <= '0;
            x_first_reg       <= '0;
            seen_reg          <= '0;
        end
        else if (advance)
        begin
            in_valid_reg    <= in_valid;
            sq_valid_reg[0] <= in_valid_reg;
            for (int k = 1; k <= SQ_N; k++)
            begin
                sq_valid_reg[k] <= sq_valid_reg[k-1];
            end
            mul_valid_reg <= sq_valid_reg[SQ_N];
            gd_valid_reg  <= mul_valid_reg;
            out_valid_reg <= gd_valid_reg && region_sel.emit;

            if (gd_valid_reg)
            begin
                if (gd_last_reg)
                begin
                    // End of stream: drop all scan state
                    point_index_reg   <= '0;
                    prev_goodness_reg <= '0;
                    prev_diff_reg     <= '0;
                    flag_older_reg    <= 1'b0;
                    flag_newer_reg    <= 1'b0;
                    x_delay_reg[0]    <= '0;
                    x_delay_reg[1]    <= '0;
                    run_reg           <= '0;
                    x_first_reg       <= '0;
                    seen_reg          <= '0;
                end
                else
                begin
                    point_index_reg   <= point_index_next;
                    prev_goodness_reg <= gd_g_reg;
                    prev_diff_reg     <= d_cur;
                    flag_older_reg    <= flag_newer_reg;
                    flag_newer_reg    <= cn;
                    x_delay_reg[1]    <= x_delay_reg[0];
                    x_delay_reg[0]    <= gd_xc_reg;
                    run_reg           <= run_next;
                    x_first_reg       <= x_first_cur;
                    if (seen_reg != 2'd3)
                    begin
                        seen_reg <= seen_reg + 2'd1;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers: advance with the pipeline, no reset
    // ------------------------------------------------------------------
    logic [11:0] start_index_reg;
    logic [11:0] stop_index_reg;
    logic [11:0] run_length_reg;
    logic [31:0] x_start_reg;
    logic [31:0] x_stop_reg;
    logic [10:0] region_number_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            in_var_reg  <= variance;
            in_x_reg    <= x_coord;
            in_last_reg <= last_point;

            sq_x_reg[0]    <= norm_x;
            sq_frac_reg[0] <= '0;
            sq_e_reg[0]    <= norm_e;
            sq_zero_reg[0] <= norm_zero;
            sq_xc_reg[0]   <= in_x_reg;
            sq_last_reg[0] <= in_last_reg;
            for (int k = 1; k <= SQ_N; k++)
            begin
                sq_x_reg[k]    <= sq_x_next[k];
                sq_frac_reg[k] <= sq_frac_next[k];
                sq_e_reg[k]    <= sq_e_reg[k-1];
                sq_zero_reg[k] <= sq_zero_reg[k-1];
                sq_xc_reg[k]   <= sq_xc_reg[k-1];
                sq_last_reg[k] <= sq_last_reg[k-1];
            end

            mul_reg      <= mul_next;
            mul_zero_reg <= sq_zero_reg[SQ_N];
            mul_xc_reg   <= sq_xc_reg[SQ_N];
            mul_last_reg <= sq_last_reg[SQ_N];

            gd_g_reg    <= g_next;
            gd_xc_reg   <= mul_xc_reg;
            gd_last_reg <= mul_last_reg;

            start_index_reg   <= region_sel.start_idx;
            stop_index_reg    <= region_sel.stop_idx;
            run_length_reg    <= region_sel.length;
            x_start_reg       <= region_sel.x_begin;
            x_stop_reg        <= region_sel.x_end;
            region_number_reg <= region_sel.number;
        end
    end

    assign out_valid     = out_valid_reg;
    assign start_index   = start_index_reg;
    assign stop_index    = stop_index_reg;
    assign run_length    = run_length_reg;
    assign x_start       = $signed(x_start_reg);
    assign x_stop        = $signed(x_stop_reg);
    assign region_number = region_number_reg;

endmodule

// ===== sim/smooth_region_segmenter_tb.sv =====
// Self-checking testbench for the smooth region segmenter: random streams against a local predictor.
module smooth_region_segmenter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Index space of a stream; the block is built with its default size.
    localparam int N_POINTS = srs_pkg::MAX_POINTS_DEFAULT;

    // Cycles to let the pipeline run dry before a register write.
    localparam int SETTLE_CYCLES = 40;

    // One input word as the driver presents it
    typedef struct {
        logic [31:0]        variance;
        logic signed [31:0] x_coord;
        logic               last_point;
    } point_t;

    // One region as the block reports it
    typedef struct packed {
        logic [11:0]        first_idx;
        logic [11:0]        last_idx;
        logic [11:0]        span;
        logic signed [31:0] x_first;
        logic signed [31:0] x_last;
        logic [10:0]        number;
    } region_t;

    // Receiver behavior, re-chosen at the end of every segment
    typedef enum int {RX_OPEN, RX_COIN, RX_STALLS, RX_SPARSE} rx_mode_e;

    logic               clk;
    logic               rst_n         = 1'b0;
    logic               in_valid      = 1'b0;
    logic               in_ready;
    logic [31:0]        variance      = '0;
    logic signed [31:0] x_coord       = '0;
    logic               last_point    = 1'b0;
    logic               out_valid;
    logic               out_ready     = 1'b0;
    logic [11:0]        start_index;
    logic [11:0]        stop_index;
    logic [11:0]        run_length;
    logic signed [31:0] x_start;
    logic signed [31:0] x_stop;
    logic [10:0]        region_number;
    logic               cfg_write     = 1'b0;
    logic               cfg_index     = srs_pkg::REG_DIFF_THRESHOLD;
    logic [15:0]        cfg_data      = '0;

    smooth_region_segmenter uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .variance      (variance),
        .x_coord       (x_coord),
        .last_point    (last_point),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .start_index   (start_index),
        .stop_index    (stop_index),
        .run_length    (run_length),
        .x_start       (x_start),
        .x_stop        (x_stop),
        .region_number (region_number),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Stimulus and scoreboard storage
    point_t  pending_points[$];
    region_t expected_regions[$];
    region_t want;

    int err_count   = 0;
    int n_points    = 0;
    int n_regions   = 0;
    int n_settings  = 0;

    // Driver state
    bit word_taken  = 1'b0;
    int burst_left  = 0;
    int gap_left    = 0;

    // Receiver state
    rx_mode_e rx_mode = RX_OPEN;
    int seg_left    = 0;
    int stall_left  = 0;

    // Register copies used by the predictor
    int thr_now     = int'(srs_pkg::DIFF_THRESHOLD_RESET);
    int min_run_now = int'(srs_pkg::MIN_RUN_RESET);

    // Predictor copy of the stream state
    int          pidx;
    int          prev_g;
    int          prev_d;
    bit          flag_old;
    bit          flag_new;
    logic [31:0] x_hist [2];
    int          pairs;
    int          begin_idx;
    logic [31:0] begin_x;
    int          regions;
    logic [31:0] x_origin;
    int          n_seen;

    //------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------

    // Goodness -2*ln(v) in Q8.8 from the raw Q16.16 variance.
    // Integer part of log2 is the MSB position; the 16 fraction bits come
    // from repeated squaring of the normalized Q1.31 mantissa.
    function automatic int log_goodness(logic [31:0] v);
        int          e;
        int          k;
        logic [15:0] frac;
        logic [63:0] acc;
        longint      lq;
        longint      prod;
        if (v == 0)
            return int'(srs_pkg::G_SAT);
        e = 0;
        while (e < 31 && (v >> (e + 1)) != 0)
            e++;
        acc  = 64'(v) << (31 - e);
        frac = '0;
        for (k = 0; k < srs_pkg::SQ_STEPS; k++)
        begin
            acc  = (acc * acc) >> 31;
            frac = frac << 1;
            if (acc >= 64'h1_0000_0000)
            begin
                frac[0] = 1'b1;
                acc     = acc >> 1;
            end
        end
        lq   = (longint'(e) - 16) * 65536 + longint'(frac);
        prod = -(lq * longint'(srs_pkg::TWO_LN2_Q16));
        // floor after adding one half: round half toward +infinity
        return int'((prod + longint'(srs_pkg::ROUND_HALF)) >>> 24);
    endfunction

    task automatic clear_stream_state();
        pidx      = 0;
        prev_g    = 0;
        prev_d    = 0;
        flag_old  = 1'b0;
        flag_new  = 1'b0;
        x_hist[0] = '0;
        x_hist[1] = '0;
        pairs     = 0;
        begin_idx = 0;
        begin_x   = '0;
        regions   = 0;
        x_origin  = '0;
        n_seen    = 0;
    endtask

    // Scan one point of the flag sequence; a run ends at a flagged point whose
    // successor is not flagged, and yields a region if its pairs exceed min_run_now.
    task automatic scan_point(input int i, input logic [31:0] xi, input bit has_prev,
                              input bit c_prev, input bit c_here, input bit c_next,
                              output bit hit, output region_t r);
        int span;
        hit = 1'b0;
        r   = '0;
        if (!c_here)
            return;
        if (c_next)
        begin
            if (pairs < int'(srs_pkg::PAIR_MAX))
                pairs++;
            // a run that starts after an unflagged point takes this index
            if (has_prev && !c_prev)
            begin
                begin_idx = i;
                begin_x   = xi;
            end
            return;
        end
        if (pairs > min_run_now)
        begin
            span        = i - begin_idx;
            r.first_idx = begin_idx[11:0];
            r.last_idx  = i[11:0];
            r.span      = span[11:0];
            r.x_first   = begin_x;
            r.x_last    = xi;
            r.number    = regions[10:0];
            pairs       = 0;
            regions     = (regions + 1) & 12'hFFF;
            hit         = 1'b1;
        end
        else
        begin
            // short run: fall back to the stream origin
            pairs     = 0;
            begin_idx = 0;
            begin_x   = x_origin;
        end
    endtask

    // Advance the predictor by one accepted word and queue any region.
    task automatic segment_point(point_t p);
        int      g;
        int      d;
        int      dx;
        int      n;
        bit      cn;
        bit      hit;
        region_t r;
        g   = log_goodness(p.variance);
        d   = 0;
        cn  = 1'b0;
        hit = 1'b0;
        n   = pidx;
        if (n_seen >= 1)
        begin
            d = g - prev_g;
            if (d < 0)
                d = -d;
            d  = d & 32'hFFFF;
            dx = d - prev_d;
            if (dx < 0)
                dx = -dx;
            cn = (dx < thr_now);
        end
        else
        begin
            x_origin  = p.x_coord;
            begin_idx = 0;
            begin_x   = p.x_coord;
        end
        if (n_seen >= 2)
            scan_point((n + N_POINTS - 2) % N_POINTS, x_hist[1], n_seen >= 3,
                       flag_old, flag_new, cn, hit, r);
        // the final point closes any run still open
        if (p.last_point && n_seen >= 1 && !hit)
            scan_point((n + N_POINTS - 1) % N_POINTS, x_hist[0], n_seen >= 2,
                       flag_new, cn, 1'b0, hit, r);
        if (hit)
            expected_regions.push_back(r);
        if (p.last_point)
        begin
            clear_stream_state();
            return;
        end
        flag_old  = flag_new;
        flag_new  = cn;
        x_hist[1] = x_hist[0];
        x_hist[0] = p.x_coord;
        prev_g    = g;
        prev_d    = d;
        pidx      = (n + 1) % N_POINTS;
        if (n_seen < 3)
            n_seen++;
    endtask

    //------------------------------------------------------------------
    // Clock
    //------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    //------------------------------------------------------------------
    // Input driver: pop pending words at the falling edge, in bursts of
    // random length separated by random gaps. Hold a word until taken.
    //------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (!in_valid || word_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_points.size() > 0)
            begin
                point_t p;
                p = pending_points.pop_front();
                variance   <= p.variance;
                x_coord    <= p.x_coord;
                last_point <= p.last_point;
                in_valid   <= 1'b1;
                if (burst_left == 0)
                begin
                    // long bursts with no gap at all now and then
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left--;
            end
            else
                in_valid <= 1'b0;
        end
    end

    //------------------------------------------------------------------
    // Receiver: ready pattern of its own, independent of the sender.
    //------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (seg_left == 0)
        begin
            rx_mode  = rx_mode_e'($urandom_range(0, 3));
            seg_left = $urandom_range(10, 200);
        end
        else
            seg_left--;
        case (rx_mode)
            RX_OPEN:
                out_ready <= 1'b1;
            RX_COIN:
                out_ready <= 1'($urandom_range(0, 1));
            RX_STALLS:
                if (stall_left > 0)
                begin
                    stall_left--;
                    out_ready <= 1'b0;
                end
                else if ($urandom_range(0, 7) == 0)
                begin
                    stall_left = $urandom_range(1, 16);
                    out_ready <= 1'b0;
                end
                else
                    out_ready <= 1'b1;
            default:
                out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    //------------------------------------------------------------------
    // Input monitor: predict from every word taken at the rising edge.
    //------------------------------------------------------------------

    always @(posedge clk)
    begin
        word_taken = rst_n && in_valid && in_ready;
        if (word_taken)
        begin
            point_t p;
            p.variance   = variance;
            p.x_coord    = x_coord;
            p.last_point = last_point;
            segment_point(p);
            n_points++;
        end
    end

    //------------------------------------------------------------------
    // Output monitor: compare every region taken with the oldest one due.
    //------------------------------------------------------------------

    task automatic report_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v)
        begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_v, got_v);
            err_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_regions.size() == 0)
            begin
                $display("%0t ns: unexpected region, expected none, actual start %0d stop %0d",
                         $time, start_index, stop_index);
                err_count++;
            end
            else
            begin
                want = expected_regions.pop_front();
                report_field("start_index",   32'(want.first_idx), 32'(start_index));
                report_field("stop_index",    32'(want.last_idx),  32'(stop_index));
                report_field("run_length",    32'(want.span),      32'(run_length));
                report_field("x_start",       want.x_first,        x_start);
                report_field("x_stop",        want.x_last,         x_stop);
                report_field("region_number", 32'(want.number),    32'(region_number));
            end
            n_regions++;
        end
    end

    //------------------------------------------------------------------
    // Stimulus helpers
    //------------------------------------------------------------------

    task automatic push_point(logic [31:0] v, logic [31:0] x, bit lastp);
        point_t p;
        p.variance   = v;
        p.x_coord    = x;
        p.last_point = lastp;
        pending_points.push_back(p);
    endtask

    // Wait until every word is taken and every region has come out, then
    // let the pipeline drain words that produce nothing.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_points.size() != 0 || in_valid || expected_regions.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write both registers on consecutive cycles; only call while idle.
    task automatic set_config(int thr_v, int min_v);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= srs_pkg::REG_DIFF_THRESHOLD;
        cfg_data  <= thr_v[15:0];
        @(negedge clk);
        cfg_index <= srs_pkg::REG_MIN_RUN;
        cfg_data  <= {4'b0, min_v[11:0]};
        @(negedge clk);
        cfg_write <= 1'b0;
        thr_now     = thr_v & 32'hFFFF;
        min_run_now = min_v & 32'hFFF;
        n_settings++;
    endtask

    // One stream ending in an end marker. Smooth streams hold a base level
    // with small relative noise and occasional jumps; noisy streams are
    // raw random words.
    task automatic queue_stream(int len, bit noisy);
        point_t      p;
        logic [31:0] base;
        logic [31:0] xpos;
        int          k;
        base = $urandom >> $urandom_range(0, 31);
        xpos = $urandom;
        for (k = 0; k < len; k++)
        begin
            if (noisy)
            begin
                case ($urandom_range(0, 7))
                    0:       p.variance = '0;
                    1:       p.variance = '1;
                    default: p.variance = $urandom;
                endcase
                p.x_coord = $urandom;
            end
            else
            begin
                if ($urandom_range(0, 11) == 0)
                    base = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 39) == 0)
                    p.variance = '0;
                else
                    p.variance = base + (base >> $urandom_range(5, 31));
                xpos      = xpos + $urandom_range(1, 32'h20000);
                p.x_coord = xpos;
            end
            p.last_point = (k == len - 1);
            pending_points.push_back(p);
        end
    endtask

    // Blocks of four equal variances with a new level per block: with an
    // exact-match threshold this yields two flagged points per block, so a
    // short region every four words.
    task automatic queue_square_wave(int len);
        logic [31:0] level;
        int          k;
        level = $urandom;
        for (k = 0; k < len; k++)
        begin
            if (k % 4 == 0)
                level = $urandom;
            push_point(level, $urandom, k == len - 1);
        end
    endtask

    //------------------------------------------------------------------
    // Main sequence
    //------------------------------------------------------------------

    initial
    begin
        int ph;
        int queued;
        int len;
        int k;

        clear_stream_state();

        // hold reset, then release it on a falling edge
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, at the reset register values.
        // Single point stream with zero variance and the largest x.
        push_point(32'h0, 32'h7FFF_FFFF, 1'b1);
        // Flat stream from the smallest x: run from point zero, closed
        // by the end marker.
        for (k = 0; k < 10; k++)
            push_point(32'h0001_0000, 32'h8000_0000 + k * 32'h1_0000, k == 9);
        // Extreme variances break the flags, then a flat tail forms a run
        // that starts mid-stream.
        push_point(32'h0000_0001, 32'h7FFF_FFF0, 1'b0);
        push_point(32'hFFFF_FFFF, 32'h7FFF_FFF1, 1'b0);
        push_point(32'h0000_0000, 32'h7FFF_FFF2, 1'b0);
        for (k = 3; k < 12; k++)
            push_point(32'h0003_0000, 32'h7FFF_FFF0 + k, k == 11);
        wait_idle();

        // Random streams under several register settings, extremes included
        for (ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: set_config(256, 5);
                1: set_config(0, 0);
                2: set_config(65535, 4095);
                3: set_config(1, 0);
                4: set_config(512, 2);
                5: set_config($urandom_range(0, 65535), $urandom_range(0, 12));
                default: set_config($urandom_range(0, 2047), $urandom_range(0, 40));
            endcase
            queued = 0;
            while (queued < 200)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2)
                                                  : $urandom_range(3, 60);
                queue_stream(len, $urandom_range(0, 6) == 0);
                queued += len;
            end
            wait_idle();
        end

        // Stream of short regions back to back: the region number counts up
        // within one stream.
        set_config(1, 0);
        queue_square_wave(120);
        wait_idle();

        // Everything flagged: one long region from point zero closes at
        // the end marker.
        set_config(65535, 100);
        queue_stream(150, 1'b1);

        // drain, then watch for stray results
        do
            @(posedge clk);
        while (pending_points.size() != 0 || in_valid || expected_regions.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d points and %0d regions over %0d register settings,",
                 n_points, n_regions, n_settings);
        $display("with bursty input, output stalls and short regions back to back.");
        if (err_count == 0)
            $display("smooth_region_segmenter_tb passed");
        else
            $display("smooth_region_segmenter_tb failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("smooth_region_segmenter_tb failed");
        $finish;
    end

endmodule
